[rtl/core/hdqub_pkg.sv]
// Shared types and constants for the HDQ-over-UART bit codec.
`default_nettype none

package hdqub_pkg;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_TX     = 2'd1,
        OP_RX     = 2'd2,
        OP_UNUSED = 2'd3
    } opcode_t;

    localparam logic [1:0] CFG_ONE_CODE      = 2'd0;
    localparam logic [1:0] CFG_ZERO_CODE     = 2'd1;
    localparam logic [1:0] CFG_ONE_THRESHOLD = 2'd2;

    localparam logic [7:0] ONE_CODE_RST      = 8'hFE;
    localparam logic [7:0] ZERO_CODE_RST     = 8'hC0;
    localparam logic [7:0] ONE_THRESHOLD_RST = 8'hF0;

    typedef struct packed {
        logic            start;
        logic            rx;
        logic [7:0]      msg_bytes;
        logic [7:0]      data;
        logic [7:0]      threshold;
        logic [7:0][7:0] echo;
    } rx_ctrl_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] rx_byte;
        logic [5:0] rx_index;
        logic       complete;
    } rx_res_t;

endpackage

`default_nettype wire

[rtl/core/hdq_over_uart_bit_codec.sv]
// Top level: HDQ-over-UART bit codec with stream ports and config write port.
// An accepted transaction's first result is registered and reaches m_tdata in the next cycle.
// Throughput: start and receive transactions one per cycle while the output is free; a
// transmit transaction holds off the input while the beat counter sends its remaining codes.
// Reset: synchronous active-low aresetn clears control state and restores the
// config registers; the echo pattern is not reset.
`default_nettype none

module hdq_over_uart_bit_codec
    import hdqub_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // tx_count[6:0], rx_count[13:7], data_byte[21:14]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // uart_byte[7:0], status[8], rx_byte[16:9],
                                        // rx_index[22:17], complete[23]
    output logic [0:0]       m_tuser,   // rx_valid[0]
    output logic             m_tlast,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int BIT_W = $clog2(MAX_MESSAGE_BYTES * 8 + 1);

    logic [7:0] one_code_reg, zero_code_reg, one_thr_reg;

    logic [7:0][7:0] echo_reg;
    logic            first_sent_reg, first_sent_next;

    logic            tx_active_reg, tx_active_next;
    logic [2:0]      beat_reg, beat_next;
    logic [7:0]      tx_data_reg, tx_data_next;

    logic            m_tvalid_reg, m_tvalid_next;
    logic [23:0]     m_tdata_reg, m_tdata_next;
    logic            m_rxv_reg, m_rxv_next;
    logic            m_tlast_reg, m_tlast_next;

    opcode_t    op;
    logic [7:0] data_in;
    logic [7:0] msg_bytes;
    logic       too_big;
    logic       out_free;
    logic       accept;
    logic       echo_wr;
    logic [7:0] beat_code;
    rx_ctrl_t   rx_ctrl;
    rx_res_t    rx_res;

    function automatic logic [23:0] pack_out(
        input logic [7:0] uart_byte,
        input logic       status,
        input logic [7:0] rx_byte,
        input logic [5:0] rx_index,
        input logic       complete
    );
        return {complete, rx_index, rx_byte, status, uart_byte};
    endfunction

    always_comb begin
        op        = opcode_t'(s_tuser);
        data_in   = s_tdata[21:14];
        msg_bytes = 8'({1'b0, s_tdata[6:0]} + {1'b0, s_tdata[13:7]});
        too_big   = {1'b0, msg_bytes} > 9'(MAX_MESSAGE_BYTES);
        out_free  = !m_tvalid_reg || m_tready;
        s_tready  = !tx_active_reg && out_free;
        accept    = s_tvalid && s_tready;
        echo_wr   = accept && (op == OP_TX) && !first_sent_reg;
        beat_code = tx_data_reg[beat_reg] ? one_code_reg : zero_code_reg;

        rx_ctrl.start     = accept && (op == OP_START) && !too_big;
        rx_ctrl.rx        = accept && (op == OP_RX);
        rx_ctrl.msg_bytes = msg_bytes;
        rx_ctrl.data      = data_in;
        rx_ctrl.threshold = one_thr_reg;
        rx_ctrl.echo      = echo_reg;
    end

    hdqub_rx_decoder #(
        .BIT_W (BIT_W)
    ) u_rx_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rx_ctrl),
        .res     (rx_res)
    );

    always_comb begin
        tx_active_next  = tx_active_reg;
        beat_next       = beat_reg;
        tx_data_next    = tx_data_reg;
        first_sent_next = first_sent_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_rxv_next      = m_rxv_reg;
        m_tlast_next    = m_tlast_reg;

        if (tx_active_reg) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = pack_out(beat_code, 1'b0, 8'd0, 6'd0, 1'b0);
                m_rxv_next    = 1'b0;
                m_tlast_next  = (beat_reg == 3'd7);
                beat_next     = beat_reg + 3'd1;
                if (beat_reg == 3'd7) begin
                    tx_active_next = 1'b0;
                end
            end
        end else if (accept) begin
            case (op)
                OP_START: begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pack_out(8'd0, too_big, 8'd0, 6'd0, 1'b0);
                    m_rxv_next    = 1'b0;
                    m_tlast_next  = 1'b0;
                    if (!too_big) begin
                        first_sent_next = 1'b0;
                    end
                end
                OP_TX: begin
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = pack_out(data_in[0] ? one_code_reg : zero_code_reg,
                                               1'b0, 8'd0, 6'd0, 1'b0);
                    m_rxv_next      = 1'b0;
                    m_tlast_next    = 1'b0;
                    tx_active_next  = 1'b1;
                    beat_next       = 3'd1;
                    tx_data_next    = data_in;
                    first_sent_next = 1'b1;
                end
                OP_RX: begin
                    if (rx_res.emit) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = pack_out(8'd0, 1'b0, rx_res.rx_byte,
                                                 rx_res.rx_index, rx_res.complete);
                        m_rxv_next    = 1'b1;
                        m_tlast_next  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_code_reg   <= ONE_CODE_RST;
            zero_code_reg  <= ZERO_CODE_RST;
            one_thr_reg    <= ONE_THRESHOLD_RST;
            first_sent_reg <= 1'b0;
            tx_active_reg  <= 1'b0;
            beat_reg       <= 3'd0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ONE_CODE:      one_code_reg  <= cfg_data;
                    CFG_ZERO_CODE:     zero_code_reg <= cfg_data;
                    CFG_ONE_THRESHOLD: one_thr_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            first_sent_reg <= first_sent_next;
            tx_active_reg  <= tx_active_next;
            beat_reg       <= beat_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tx_data_reg <= tx_data_next;
        m_tdata_reg <= m_tdata_next;
        m_rxv_reg   <= m_rxv_next;
        m_tlast_reg <= m_tlast_next;
        if (echo_wr) begin
            for (int i = 0; i < 8; i++) begin
                echo_reg[i] <= data_in[i] ? one_code_reg : zero_code_reg;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_rxv_reg;
    assign m_tlast    = m_tlast_reg;

    a_tx_starts_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (op == OP_TX) |=> tx_active_reg && m_tvalid && !m_tlast)
        else $error("transmit transaction did not start an encoded burst");

    a_last_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_active_reg && out_free && (beat_reg == 3'd7)
        |=> m_tvalid && m_tlast && !tx_active_reg)
        else $error("eighth encoded byte not marked last");

    a_last_not_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tlast && m_tuser[0]))
        else $error("decoded byte marked as last encoded byte");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_active_reg && (beat_reg != 3'd7) |=> !s_tready)
        else $error("input accepted during encoded burst");

endmodule

`default_nettype wire

[rtl/core/hdqub_rx_decoder.sv]
// Receive-side bit decoder: echo check, threshold decode and byte assembly.
`default_nettype none

module hdqub_rx_decoder
    import hdqub_pkg::*;
#(
    parameter int BIT_W = 10
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire rx_ctrl_t ctrl,
    output rx_res_t       res
);

    logic [BIT_W-1:0] bit_index_reg, bit_index_next;
    logic [BIT_W-1:0] expected_reg, expected_next;
    logic [7:0]       asm_reg, asm_next;

    logic [BIT_W-1:0] j_inc;
    logic [2:0]       pos;
    logic             echo_ok;
    logic             take;
    logic             hit;
    logic [7:0]       asm_base;
    logic [7:0]       asm_new;

    always_comb begin
        pos      = bit_index_reg[2:0];
        j_inc    = bit_index_reg + BIT_W'(1);
        echo_ok  = (bit_index_reg >= BIT_W'(8)) || (ctrl.data == ctrl.echo[pos]);
        take     = ctrl.rx && echo_ok && (bit_index_reg < expected_reg);
        hit      = ctrl.data >= ctrl.threshold;
        asm_base = (pos == 3'd0) ? 8'd0 : asm_reg;
        asm_new  = asm_base | (8'(hit) << pos);

        bit_index_next = bit_index_reg;
        expected_next  = expected_reg;
        asm_next       = asm_reg;
        if (ctrl.start) begin
            bit_index_next = '0;
            expected_next  = BIT_W'({3'b000, ctrl.msg_bytes, 3'b000});
            asm_next       = '0;
        end else if (take) begin
            bit_index_next = j_inc;
            asm_next       = asm_new;
        end

        res.emit     = take && (pos == 3'd7);
        res.rx_byte  = asm_new;
        res.rx_index = 6'(bit_index_reg >> 3);
        res.complete = j_inc >= expected_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_index_reg <= '0;
            expected_reg  <= '0;
            asm_reg       <= '0;
        end else begin
            bit_index_reg <= bit_index_next;
            expected_reg  <= expected_next;
            asm_reg       <= asm_next;
        end
    end

    a_index_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_index_reg <= expected_reg)
        else $error("bit index ran past expected bit count");

    a_emit_on_byte_end: assert property (@(posedge aclk) disable iff (!aresetn)
        res.emit |=> bit_index_reg[2:0] == 3'd0)
        else $error("byte emitted off a byte boundary");

endmodule

`default_nettype wire
